// ----- rtl/angular_occlusion_range_set_assert.svh -----
// Assertion macros used by the checker file of the range set.
`ifndef ANGULAR_OCCLUSION_RANGE_SET_ASSERT_SVH
`define ANGULAR_OCCLUSION_RANGE_SET_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AORS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AORS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aors_pkg.sv -----
// Package with sizes, codes and control types of the occlusion range set.
package aors_pkg;

  localparam int MAX_RANGES = 64;
  localparam int CW         = $clog2(MAX_RANGES + 1);
  localparam int AW         = $clog2(MAX_RANGES);
  localparam int ANGLE_W    = 32;
  localparam int CMD_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_INC} idx_op_t;
  typedef enum logic [2:0] {K_HOLD, K_IDX, K_IDX1, K_CNT, K_INC, K_DEC} k_op_t;
  typedef enum logic [1:0] {RD_IDX, RD_IDX1, RD_K1, RD_KM1} rd_sel_t;
  typedef enum logic {WA_IDX, WA_K} wa_sel_t;
  typedef enum logic [3:0] {
    WD_COPY, WD_START_S, WD_START_E, WD_END_E, WD_END_S,
    WD_MERGE, WD_HEND_E, WD_NEW, WD_SPLIT
  } wd_sel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_INC, CNT_DEC} cnt_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_Q_RD, ST_Q_CHK, ST_P1_RD, ST_P1_CHK, ST_P2_RD, ST_P2_CHK,
    ST_MRG, ST_P3_RD, ST_P3_CHK, ST_INS_GO, ST_INS_RD, ST_INS_WR,
    ST_DEL_RD, ST_DEL_WR, ST_FIN
  } state_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    k_op_t   k_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    hold_ld;
    cnt_op_t cnt_op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic idx_lt_cnt;
    logic idx1_lt_cnt;
    logic k1_lt_cnt;
    logic k_gt_idx;
    logic full;
    logic e_zero;
    logic st_zero;
    logic st_lt_e;
    logic st_ge_s;
    logic st_le_e;
    logic st_le_s;
    logic st_lt_s;
    logic en_le_e;
    logic en_ge_e;
    logic en_ge_s;
    logic en_gt_e;
  } dp_stat_t;

endpackage

// ----- rtl/aors_if.sv -----
// Valid/ready channel interfaces for command items and result items.
interface aors_in_if;
  logic                          valid;
  logic                          ready;
  logic [aors_pkg::CMD_W-1:0]    command;
  logic [aors_pkg::ANGLE_W-1:0]  start_angle;
  logic [aors_pkg::ANGLE_W-1:0]  end_angle;
  modport source (output valid, command, start_angle, end_angle, input ready);
  modport sink   (input valid, command, start_angle, end_angle, output ready);
endinterface

interface aors_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic table_full;
  modport source (output valid, visible, table_full, input ready);
  modport sink   (input valid, visible, table_full, output ready);
endinterface

// ----- rtl/angular_occlusion_range_set.sv -----
// Top level of the occluded angle range set.
// The block keeps up to MAX_RANGES occluded ranges in a single-port memory
// with registered read data and runs one command item at a time, giving one
// result item per command. A clear gives its result in the cycle after it is
// taken. Other commands walk the table: each entry scanned is read, then
// compared, and each entry moved when a range is deleted or inserted is read,
// then written back. Each deletion shifts the rest of the table through the
// one memory port, so an add or a remove that deletes many entries of a full
// table is the slowest case.
// A new item is taken once the previous result item has been delivered.
module angular_occlusion_range_set (
  input logic  clk,
  input logic  rst_n,
  aors_in_if.sink    in_ch,
  aors_out_if.source out_ch
);
  import aors_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  aors_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_command     (cmd_t'(in_ch.command)),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_visible    (out_ch.visible),
    .out_table_full (out_ch.table_full),
    .stat           (stat),
    .ctl            (ctl)
  );

  aors_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_command (cmd_t'(in_ch.command)),
    .in_start   (in_ch.start_angle),
    .in_end     (in_ch.end_angle),
    .stat       (stat)
  );
endmodule

// ----- rtl/aors_datapath.sv -----
// Datapath with the range table memory, scan counters and comparators.
module aors_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aors_pkg::dp_cmd_t            ctl,
  input  aors_pkg::cmd_t               in_command,
  input  logic [aors_pkg::ANGLE_W-1:0] in_start,
  input  logic [aors_pkg::ANGLE_W-1:0] in_end,
  output aors_pkg::dp_stat_t           stat
);
  import aors_pkg::*;

  logic [2*ANGLE_W-1:0] mem [MAX_RANGES];
  logic [2*ANGLE_W-1:0] ent_r, hold_r, wd;
  logic [ANGLE_W-1:0]   s_r, e_r, ent_st, ent_en;
  cmd_t                 cmd_r;
  logic [CW-1:0]        idx_r, idx_nxt, k_r, k_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0]        idx1, k1, km1, rd_cnt, wa_cnt;

  assign idx1   = idx_r + CW'(1);
  assign k1     = k_r + CW'(1);
  assign km1    = k_r - CW'(1);
  assign ent_st = ent_r[2*ANGLE_W-1:ANGLE_W];
  assign ent_en = ent_r[ANGLE_W-1:0];

  always_comb begin
    case (ctl.rd_sel)
      RD_IDX:  rd_cnt = idx_r;
      RD_IDX1: rd_cnt = idx1;
      RD_K1:   rd_cnt = k1;
      RD_KM1:  rd_cnt = km1;
      default: rd_cnt = idx_r;
    endcase
    wa_cnt = (ctl.wa_sel == WA_K) ? k_r : idx_r;
    case (ctl.wd_sel)
      WD_COPY:    wd = ent_r;
      WD_START_S: wd = {s_r, ent_en};
      WD_START_E: wd = {e_r, ent_en};
      WD_END_E:   wd = {ent_st, e_r};
      WD_END_S:   wd = {ent_st, s_r};
      WD_MERGE:   wd = {hold_r[2*ANGLE_W-1:ANGLE_W], ent_en};
      WD_HEND_E:  wd = {hold_r[2*ANGLE_W-1:ANGLE_W], e_r};
      WD_NEW:     wd = {s_r, e_r};
      WD_SPLIT:   wd = {e_r, hold_r[ANGLE_W-1:0]};
      default:    wd = ent_r;
    endcase
    case (ctl.idx_op)
      IDX_ZERO: idx_nxt = '0;
      IDX_INC:  idx_nxt = idx1;
      default:  idx_nxt = idx_r;
    endcase
    case (ctl.k_op)
      K_IDX:   k_nxt = idx_r;
      K_IDX1:  k_nxt = idx1;
      K_CNT:   k_nxt = cnt_r;
      K_INC:   k_nxt = k1;
      K_DEC:   k_nxt = km1;
      default: k_nxt = k_r;
    endcase
    case (ctl.cnt_op)
      CNT_ZERO: cnt_nxt = '0;
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wa_cnt[AW-1:0]] <= wd;
    end
    if (ctl.rd_en) begin
      ent_r <= mem[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
    if (ctl.load) begin
      s_r   <= in_start;
      e_r   <= in_end;
      cmd_r <= in_command;
    end
    if (ctl.hold_ld) begin
      hold_r <= ent_r;
    end
  end

  always_comb begin
    stat.cmd         = cmd_r;
    stat.idx_lt_cnt  = idx_r < cnt_r;
    stat.idx1_lt_cnt = idx1 < cnt_r;
    stat.k1_lt_cnt   = k1 < cnt_r;
    stat.k_gt_idx    = k_r > idx_r;
    stat.full        = cnt_r >= CW'(MAX_RANGES);
    stat.e_zero      = e_r == '0;
    stat.st_zero     = ent_st == '0;
    stat.st_lt_e     = ent_st < e_r;
    stat.st_ge_s     = ent_st >= s_r;
    stat.st_le_e     = ent_st <= e_r;
    stat.st_le_s     = ent_st <= s_r;
    stat.st_lt_s     = ent_st < s_r;
    stat.en_le_e     = ent_en <= e_r;
    stat.en_ge_e     = ent_en >= e_r;
    stat.en_ge_s     = ent_en >= s_r;
    stat.en_gt_e     = ent_en > e_r;
  end
endmodule

// ----- rtl/aors_ctrl.sv -----
// Controller state machine that sequences scans, shifts and result items.
module aors_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aors_pkg::cmd_t     in_command,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_visible,
  output logic               out_table_full,
  input  aors_pkg::dp_stat_t stat,
  output aors_pkg::dp_cmd_t  ctl
);
  import aors_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt, vis_r, vis_nxt, full_r, full_nxt;
  logic   fin, fin_vis, fin_full;

  assign in_ready       = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_visible    = vis_r;
  assign out_table_full = full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vis_r  <= vis_nxt;
    full_r <= full_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fin       = 1'b0;
    fin_vis   = 1'b0;
    fin_full  = 1'b0;
    ctl       = '{load: 1'b0, idx_op: IDX_HOLD, k_op: K_HOLD, rd_en: 1'b0,
                  rd_sel: RD_IDX, wr_en: 1'b0, wa_sel: WA_IDX, wd_sel: WD_COPY,
                  hold_ld: 1'b0, cnt_op: CNT_HOLD};
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.load   = 1'b1;
          ctl.idx_op = IDX_ZERO;
          case (in_command)
            CMD_CLEAR: begin
              ctl.cnt_op = CNT_ZERO;
              fin        = 1'b1;
            end
            CMD_QUERY: state_nxt = ST_Q_RD;
            default:   state_nxt = ST_P1_RD;
          endcase
        end
      end
      ST_Q_RD: begin
        if (!stat.idx_lt_cnt) begin
          fin       = 1'b1;
          fin_vis   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = ST_Q_CHK;
        end
      end
      ST_Q_CHK: begin
        if (stat.e_zero) begin
          fin       = 1'b1;
          fin_vis   = !stat.st_zero;
          state_nxt = ST_IDLE;
        end else if (!stat.st_lt_e) begin
          fin       = 1'b1;
          fin_vis   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.st_le_s && stat.en_ge_e) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.idx_op = IDX_INC;
          state_nxt  = ST_Q_RD;
        end
      end
      ST_P1_RD: begin
        if (!stat.idx_lt_cnt) begin
          ctl.idx_op = IDX_ZERO;
          state_nxt  = ST_P2_RD;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = ST_P1_CHK;
        end
      end
      ST_P1_CHK: begin
        if (!stat.st_lt_e) begin
          ctl.idx_op = IDX_ZERO;
          state_nxt  = ST_P2_RD;
        end else if (stat.st_ge_s && stat.en_le_e) begin
          ctl.k_op  = K_IDX;
          ret_nxt   = ST_P1_RD;
          state_nxt = ST_DEL_RD;
        end else if (stat.cmd == CMD_ADD && stat.st_le_s && stat.en_ge_e) begin
          state_nxt = ST_FIN;
        end else begin
          ctl.idx_op = IDX_INC;
          state_nxt  = ST_P1_RD;
        end
      end
      ST_P2_RD: begin
        if (!stat.idx_lt_cnt) begin
          ctl.idx_op = IDX_ZERO;
          state_nxt  = (stat.cmd == CMD_ADD) ? ST_P3_RD : ST_FIN;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = ST_P2_CHK;
        end
      end
      ST_P2_CHK: begin
        if (stat.st_ge_s && stat.st_le_e) begin
          ctl.wr_en  = 1'b1;
          ctl.wd_sel = (stat.cmd == CMD_ADD) ? WD_START_S : WD_START_E;
          state_nxt  = ST_FIN;
        end else if (stat.en_ge_s && stat.en_le_e) begin
          if (stat.cmd == CMD_ADD) begin
            ctl.hold_ld = 1'b1;
            if (stat.idx1_lt_cnt) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_IDX1;
              state_nxt  = ST_MRG;
            end else begin
              ctl.wr_en  = 1'b1;
              ctl.wd_sel = WD_END_E;
              state_nxt  = ST_FIN;
            end
          end else begin
            ctl.wr_en  = 1'b1;
            ctl.wd_sel = WD_END_S;
            ctl.idx_op = IDX_INC;
            state_nxt  = ST_P2_RD;
          end
        end else if (stat.cmd != CMD_ADD && stat.st_lt_s && stat.en_gt_e) begin
          ctl.wr_en   = 1'b1;
          ctl.wd_sel  = WD_END_S;
          ctl.hold_ld = 1'b1;
          ctl.idx_op  = IDX_INC;
          state_nxt   = ST_INS_GO;
        end else begin
          ctl.idx_op = IDX_INC;
          state_nxt  = ST_P2_RD;
        end
      end
      ST_MRG: begin
        ctl.wr_en = 1'b1;
        if (stat.st_le_e) begin
          ctl.wd_sel = WD_MERGE;
          ctl.k_op   = K_IDX1;
          ret_nxt    = ST_FIN;
          state_nxt  = ST_DEL_RD;
        end else begin
          ctl.wd_sel = WD_HEND_E;
          state_nxt  = ST_FIN;
        end
      end
      ST_P3_RD: begin
        if (!stat.idx_lt_cnt) begin
          state_nxt = ST_INS_GO;
        end else begin
          ctl.rd_en = 1'b1;
          state_nxt = ST_P3_CHK;
        end
      end
      ST_P3_CHK: begin
        if (stat.st_lt_e) begin
          ctl.idx_op = IDX_INC;
          state_nxt  = ST_P3_RD;
        end else begin
          state_nxt = ST_INS_GO;
        end
      end
      ST_INS_GO: begin
        if (stat.full) begin
          fin       = 1'b1;
          fin_full  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.k_op  = K_CNT;
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        if (stat.k_gt_idx) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_KM1;
          state_nxt  = ST_INS_WR;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wd_sel = (stat.cmd == CMD_ADD) ? WD_NEW : WD_SPLIT;
          ctl.cnt_op = CNT_INC;
          state_nxt  = ST_FIN;
        end
      end
      ST_INS_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wa_sel = WA_K;
        ctl.k_op   = K_DEC;
        state_nxt  = ST_INS_RD;
      end
      ST_DEL_RD: begin
        if (stat.k1_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_K1;
          state_nxt  = ST_DEL_WR;
        end else begin
          ctl.cnt_op = CNT_DEC;
          state_nxt  = ret_r;
        end
      end
      ST_DEL_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wa_sel = WA_K;
        ctl.k_op   = K_INC;
        state_nxt  = ST_DEL_RD;
      end
      ST_FIN: begin
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    vis_nxt       = vis_r;
    full_nxt      = full_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
      vis_nxt       = fin_vis;
      full_nxt      = fin_full;
    end
  end
endmodule

// ----- rtl/aors_checker.sv -----
// Port-level checker for the occluded angle range set, bound to the top level.
`include "angular_occlusion_range_set_assert.svh"

module aors_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [aors_pkg::CMD_W-1:0] in_command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_visible,
  input logic                       out_table_full
);
  import aors_pkg::*;

  `AORS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `AORS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "item taken while busy")
  `AORS_ASSERT_NOW(a_one_open, clk, rst_n, out_valid, !in_ready, "ready with result pending")
  `AORS_ASSERT_NEXT(a_clear, clk, rst_n, in_valid && in_ready && in_command == CMD_CLEAR, out_valid && !out_visible && !out_table_full, "clear result wrong")
  `AORS_ASSERT_NOW(a_flags, clk, rst_n, out_valid && out_visible, !out_table_full, "both flags set")
endmodule

bind angular_occlusion_range_set aors_checker u_aors_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.command),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_visible    (out_ch.visible),
  .out_table_full (out_ch.table_full)
);
